// File: hdl/ist_pkg.sv
// Shared types and codes for the integer set table.
// No dependencies; the cell and the top level use it by scoped names.
package ist_pkg;

   localparam int unsigned ENTRY_W  = 32;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   // action codes; the unused code behaves as a lookup
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

   typedef enum logic {
      STATE_IDLE,
      STATE_EVAL
   } state_type;

   // per-cell control from the top level
   typedef struct packed {
      logic occupied;  // slot lies below the fill count
      logic load;      // write the request value into this slot
      logic del_go;    // a delete of a present value commits this cycle
   } cell_ctrl_type;

endpackage

// File: hdl/ist_cell.sv
// One slot of the set: holds an entry, compares it with the request value
// and takes its neighbor's entry when a delete closes the gap. Uses ist_pkg.
module ist_cell (
   input  logic                             clock,
   input  ist_pkg::cell_ctrl_type           ctrl,
   input  logic [ist_pkg::ENTRY_W-1:0]      value,
   input  logic [ist_pkg::ENTRY_W-1:0]      next_entry,
   input  logic                             hit_chain_in,
   output logic                             hit_chain_out,
   output logic [ist_pkg::ENTRY_W-1:0]      entry
);

   logic [ist_pkg::ENTRY_W-1:0] entry_ff;
   logic [ist_pkg::ENTRY_W-1:0] entry_in;
   logic                        hit;

   assign hit           = ctrl.occupied && (entry_ff == value);
   assign hit_chain_out = hit_chain_in | hit;
   assign entry         = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      // shift down every slot at or after the matching one
      if (ctrl.del_go && hit_chain_out) begin
         entry_in = next_entry;
      end else if (ctrl.load) begin
         entry_in = value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/integer_set_table_top.sv
// Top level of the integer set table: request/response handshake, control
// sequencer and the row of ist_cell slots. Uses ist_pkg.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+-----------
//  request | req_valid req_stall req_action req_value     | in  (stall out)
//  result  | rsp_valid rsp_stall rsp_status rsp_found     | out (stall in)
//          | rsp_count rsp_empty_res                      |
//
// Each request beat is first accepted, which latches action and value, and
// then evaluated, which compares against all slots, ripples the hit chain along
// the row of cells, commits the update and loads the result register.
// No new beat is accepted while one is being evaluated.
// Reset (synchronous, active high) empties the set and drops any pending
// result; slot contents are not cleared, since only slots below the count
// are ever compared. A stalled result holds the next request off until the
// result register frees; a request is accepted in the cycle the waiting
// result is taken.
module integer_set_table_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ist_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [ist_pkg::ENTRY_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ist_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic [ist_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_empty_res
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ist_pkg::state_type              state_ff, state_in;
   logic [ist_pkg::ACTION_W-1:0]    action_ff;
   logic [ist_pkg::ENTRY_W-1:0]     value_ff;
   logic [CNT_W-1:0]                count_ff, count_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ist_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                            rsp_found_ff;
   logic [CNT_W-1:0]                rsp_cnt_ff;

   logic                            accept;
   logic                            eval_go;
   logic                            present;
   logic                            full;
   logic                            do_insert;
   logic                            do_delete;

   logic [DEPTH:0]                  hit_chain;
   logic [ist_pkg::ENTRY_W-1:0]     entry [DEPTH];

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ist_pkg::STATE_IDLE: if (accept) state_in = ist_pkg::STATE_EVAL;
         ist_pkg::STATE_EVAL: state_in = ist_pkg::STATE_IDLE;
         default:             state_in = ist_pkg::STATE_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      eval_go   = 1'b0;
      unique case (state_ff)
         // take a beat only when the result register is free by next cycle
         ist_pkg::STATE_IDLE: req_stall = rsp_valid_ff && rsp_stall;
         ist_pkg::STATE_EVAL: eval_go   = 1'b1;
         default:             req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ist_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the request for the evaluate cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
   end

   // ---------------- row of cells ----------------
   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ist_pkg::cell_ctrl_type      ctrl;
      logic [ist_pkg::ENTRY_W-1:0] nxt;

      assign ctrl.occupied = (CNT_W'(i) < count_ff);
      assign ctrl.load     = do_insert && (CNT_W'(i) == count_ff);
      assign ctrl.del_go   = do_delete;

      // last slot keeps its own entry; it falls outside the count anyway
      if (i == DEPTH - 1) begin : g_last
         assign nxt = entry[i];
      end else begin : g_mid
         assign nxt = entry[i+1];
      end

      ist_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .value         (value_ff),
         .next_entry    (nxt),
         .hit_chain_in  (hit_chain[i]),
         .hit_chain_out (hit_chain[i+1]),
         .entry         (entry[i])
      );
   end

   // ---------------- decision ----------------
   assign present = hit_chain[DEPTH];
   assign full    = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      do_insert     = 1'b0;
      do_delete     = 1'b0;
      rsp_status_in = ist_pkg::STAT_ABSENT;
      unique case (action_ff)
         ist_pkg::ACT_INSERT: begin
            if (present) begin
               rsp_status_in = ist_pkg::STAT_PRESENT;
            end else if (full) begin
               rsp_status_in = ist_pkg::STAT_FULL;
            end else begin
               rsp_status_in = ist_pkg::STAT_DONE;
               do_insert     = eval_go;
            end
         end
         ist_pkg::ACT_DELETE: begin
            if (present) begin
               rsp_status_in = ist_pkg::STAT_DONE;
               do_delete     = eval_go;
            end
         end
         default: begin
            // lookup, and the unused code treated as one
            if (present) rsp_status_in = ist_pkg::STAT_DONE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eval_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= present;
         rsp_cnt_ff    <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_count     = ist_pkg::COUNT_W'(rsp_cnt_ff);
   assign rsp_empty_res = (rsp_cnt_ff == '0);

endmodule

// File: sim/testbench.sv
// Self-checking testbench for integer_set_table_top: directed and random set
// actions against an in-bench model of the table. Depends on hdl/ist_pkg.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam int unsigned POOL_SIZE   = 24;

   // the fourth action code has no name in the package; the block treats it
   // as a lookup
   localparam logic [ist_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

   // one expected response beat
   typedef struct packed {
      logic [ist_pkg::STATUS_W-1:0] status;
      logic                         found;
      logic [ist_pkg::COUNT_W-1:0]  count;
      logic                         empty_res;
   } set_result_type;

   // drive every input to a known value from time zero
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [ist_pkg::ACTION_W-1:0]       req_action = ist_pkg::ACT_LOOKUP;
   logic signed [ist_pkg::ENTRY_W-1:0] req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [ist_pkg::STATUS_W-1:0]       rsp_status;
   logic                               rsp_found;
   logic [ist_pkg::COUNT_W-1:0]        rsp_count;
   logic                               rsp_empty_res;

   // model of the table contents, kept in insertion order
   logic [ist_pkg::ENTRY_W-1:0] table_vals [TABLE_DEPTH];
   int unsigned                 table_count = 0;

   set_result_type              pending_results [$];
   logic [ist_pkg::ENTRY_W-1:0] value_pool [POOL_SIZE];
   int                          errors = 0;
   int                          tx_idle_pct = 0;
   int                          rx_stall_pct = 0;
   int                          hold_cycles = 0;

   integer_set_table_top #(
      .DEPTH(TABLE_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_count    (rsp_count),
      .rsp_empty_res(rsp_empty_res)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Apply one action to the table model and return the response it yields.
   // Values match as raw 32-bit patterns; a delete closes the gap so the
   // survivors keep their order.
   function automatic set_result_type apply_set_action(
         logic [ist_pkg::ACTION_W-1:0] act, logic [ist_pkg::ENTRY_W-1:0] val);
      set_result_type res;
      int             hit;
      hit = -1;
      for (int i = 0; i < int'(table_count); i++) begin
         if (hit < 0 && table_vals[i] == val) begin
            hit = i;
         end
      end
      case (act)
         ist_pkg::ACT_INSERT: begin
            if (hit >= 0) begin
               res.status = ist_pkg::STAT_PRESENT;
            end else if (table_count >= TABLE_DEPTH) begin
               res.status = ist_pkg::STAT_FULL;
            end else begin
               table_vals[table_count] = val;
               table_count++;
               res.status = ist_pkg::STAT_DONE;
            end
         end
         ist_pkg::ACT_DELETE: begin
            if (hit >= 0) begin
               for (int i = hit; i + 1 < int'(table_count); i++) begin
                  table_vals[i] = table_vals[i + 1];
               end
               table_count--;
               res.status = ist_pkg::STAT_DONE;
            end else begin
               res.status = ist_pkg::STAT_ABSENT;
            end
         end
         // lookup, and the spare code that behaves as one
         default: begin
            res.status = (hit >= 0) ? ist_pkg::STAT_DONE : ist_pkg::STAT_ABSENT;
         end
      endcase
      res.found     = (hit >= 0);
      res.count     = ist_pkg::COUNT_W'(table_count);
      res.empty_res = (table_count == 0);
      return res;
   endfunction

   function automatic void compare_field(string field, int unsigned want,
                                         int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $realtime, field, want, got);
      end
   endfunction

   // Predict at the request handshake: every accepted beat yields one response.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_results.insert(pending_results.size(),
                                apply_set_action(req_action, req_value));
      end
   end

   // Check each accepted response beat against the oldest prediction.
   always @(posedge clock) begin
      set_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat, expected none, actual status %0d count %0d",
                     $realtime, rsp_status, rsp_count);
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("found", 32'(want.found), 32'(rsp_found));
            compare_field("count", 32'(want.count), 32'(rsp_count));
            compare_field("empty_res", 32'(want.empty_res), 32'(rsp_empty_res));
         end
      end
   end

   // Receiver: hold off for a counted stretch when asked, otherwise stall at
   // the current random rate.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   // Send one request beat. Idle first at the current sender rate, scrambling
   // the payload while valid is low, then hold the beat until it is taken.
   // Leave valid high on return so back-to-back beats need no second update.
   task automatic send_beat(logic [ist_pkg::ACTION_W-1:0] act,
                            logic [ist_pkg::ENTRY_W-1:0] val);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid  <= 1'b0;
         req_action <= ist_pkg::ACTION_W'($urandom);
         req_value  <= $urandom;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Draw a fresh pool of candidate values; keep the pool a bit larger than
   // the table so inserts reach the full case and lookups still hit often.
   task automatic refresh_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         value_pool[i] = $urandom;
      end
      value_pool[$urandom_range(POOL_SIZE - 1)] = 32'h8000_0000;
      value_pool[$urandom_range(POOL_SIZE - 1)] = 32'h7FFF_FFFF;
      value_pool[$urandom_range(POOL_SIZE - 1)] = 32'hFFFF_FFFF;
      value_pool[$urandom_range(POOL_SIZE - 1)] = 32'h0000_0000;
   endtask

   function automatic logic [ist_pkg::ENTRY_W-1:0] pick_value();
      if ($urandom_range(99) < 85) begin
         return value_pool[$urandom_range(POOL_SIZE - 1)];
      end
      return $urandom;
   endfunction

   function automatic logic [ist_pkg::ACTION_W-1:0] pick_action(int insert_pct);
      int r;
      if ($urandom_range(99) < insert_pct) begin
         return ist_pkg::ACT_INSERT;
      end
      r = $urandom_range(9);
      if (r < 6) return ist_pkg::ACT_DELETE;
      if (r < 9) return ist_pkg::ACT_LOOKUP;
      return ACT_SPARE;
   endfunction

   // Random traffic; swing the insert bias every 40 beats so the fill count
   // sweeps between empty and full.
   task automatic run_random_phase(int items, int tx_pct, int rx_pct);
      int insert_pct;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      refresh_pool();
      for (int n = 0; n < items; n++) begin
         insert_pct = ((n / 40) % 2 == 0) ? 75 : 25;
         send_beat(pick_action(insert_pct), pick_value());
      end
   endtask

   // Extremes of the value range, every action and each corner: duplicate
   // insert, insert into a full table, delete of an absent value, delete at
   // the head, middle and tail, and the spare action code.
   task automatic test_directed_cases();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      send_beat(ist_pkg::ACT_LOOKUP, 32'h0000_0005);
      send_beat(ist_pkg::ACT_DELETE, 32'h0000_0005);
      send_beat(ist_pkg::ACT_INSERT, 32'h8000_0000);
      send_beat(ist_pkg::ACT_INSERT, 32'h7FFF_FFFF);
      send_beat(ist_pkg::ACT_INSERT, 32'h0000_0000);
      send_beat(ist_pkg::ACT_INSERT, 32'hFFFF_FFFF);
      send_beat(ist_pkg::ACT_INSERT, 32'hFFFF_FFFF);
      send_beat(ACT_SPARE, 32'h7FFF_FFFF);
      send_beat(ACT_SPARE, 32'h1234_5678);
      // fill the remaining slots
      for (int i = 1; i <= 12; i++) begin
         send_beat(ist_pkg::ACT_INSERT, i * 32'h0101_0101);
      end
      send_beat(ist_pkg::ACT_INSERT, 32'h5555_AAAA);
      send_beat(ist_pkg::ACT_INSERT, 32'h8000_0000);
      send_beat(ist_pkg::ACT_DELETE, 32'h0000_0000);
      send_beat(ist_pkg::ACT_LOOKUP, 32'h0000_0000);
      send_beat(ist_pkg::ACT_DELETE, 32'h8000_0000);
      send_beat(ist_pkg::ACT_DELETE, 32'h0C0C_0C0C);
      wait_for_drain();
   endtask

   task automatic test_streaming();
      run_random_phase(200, 0, 0);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(150, 73, 0);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(150, 0, 73);
   endtask

   task automatic test_mixed_idling();
      run_random_phase(200, 23, 23);
   endtask

   // Hold the receiver off for a long stretch while the sender keeps offering
   // beats back to back, so the block fills and stalls its input; then pause
   // the sender until the backlog drains, and end with random receiver stalls.
   task automatic test_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      refresh_pool();
      hold_cycles = 120;
      for (int n = 0; n < 30; n++) begin
         send_beat(pick_action(60), pick_value());
      end
      wait_for_drain();
      run_random_phase(70, 0, 50);
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      // let the prediction for the last accepted beat land first
      @(posedge clock);
      for (int w = 0; w < 20000 && pending_results.size() != 0; w++) begin
         @(posedge clock);
      end
      if (pending_results.size() != 0) begin
         errors += pending_results.size();
         $display("%0t: %0d expected responses never arrived",
                  $realtime, pending_results.size());
      end
      // let any stray beat show up before the verdict
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   endtask

   initial begin
      // hold reset at the start, then release it once for the whole run
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_backpressure();
      finish_run();
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule

// File: integer_set_table_top.f
hdl/ist_pkg.sv
hdl/ist_cell.sv
hdl/integer_set_table_top.sv
sim/testbench.sv
